FILE: hdl/generational_slot_map_macros.svh
// Assertion helpers for the slot map.
`ifndef GENERATIONAL_SLOT_MAP_MACROS_SVH
`define GENERATIONAL_SLOT_MAP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define GSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/gsm_pkg.sv
package gsm_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int GEN_WIDTH_DEF  = 32;

  localparam int REQ_W   = 2;
  localparam int SLOT_W  = 8;
  localparam int KGEN_W  = 32;
  localparam int VALUE_W = 32;
  localparam int TDATA_W = 72;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic capture;
    logic set_full;
    logic take_fresh;
    logic pop_rd;
    logic pop_take;
    logic ins_write;
    logic key_rd;
    logic dense_rd;
    logic set_invalid;
    logic rm_write;
    logic set_lookup;
    logic fix_write;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_insert;
    logic is_remove;
    logic is_lookup;
    logic full;
    logic fresh;
    logic key_range_ok;
    logic key1_ok;
    logic owner_ok;
    logic moved;
  } flags_t;

endpackage

FILE: hdl/gsm_datapath.sv
module gsm_datapath #(
  parameter int CAPACITY   = gsm_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = gsm_pkg::DATA_WIDTH_DEF,
  parameter int GEN_WIDTH  = gsm_pkg::GEN_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  gsm_pkg::cmd_t                cmd,
  output gsm_pkg::flags_t              flags,
  input  logic [gsm_pkg::REQ_W-1:0]    req_type,
  input  logic [gsm_pkg::SLOT_W-1:0]   key_slot,
  input  logic [gsm_pkg::KGEN_W-1:0]   key_gen,
  input  logic [gsm_pkg::VALUE_W-1:0]  value,
  output logic [1:0]                   status,
  output logic [gsm_pkg::SLOT_W-1:0]   out_slot,
  output logic [gsm_pkg::KGEN_W-1:0]   out_gen,
  output logic [gsm_pkg::VALUE_W-1:0]  value_out
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = AW + 1;
  localparam int XW = CW + gsm_pkg::SLOT_W;

  // request
  logic [gsm_pkg::REQ_W-1:0]  req_q;
  logic [XW-1:0]              ks_q;
  logic [GEN_WIDTH-1:0]       kg_q;
  logic [DATA_WIDTH-1:0]      val_q;

  // table state
  logic [CW-1:0]              free_head;
  logic [CW-1:0]              live_count;
  logic [CW-1:0]              high_water;
  logic [GEN_WIDTH-1:0]       gen_counter;

  // work registers
  logic [CW-1:0]              slot_q;
  logic [CW-1:0]              hole_q;

  // memories
  logic [CW-1:0]              slot_link       [CAPACITY];
  logic [GEN_WIDTH-1:0]       slot_generation [CAPACITY];
  logic [DATA_WIDTH-1:0]      dense_values    [CAPACITY];
  logic [AW-1:0]              dense_owner     [CAPACITY];

  logic [CW-1:0]              link_rd;
  logic [GEN_WIDTH-1:0]       gen_rd;
  logic [DATA_WIDTH-1:0]      val_a;
  logic [DATA_WIDTH-1:0]      val_b;
  logic [AW-1:0]              owner_a;
  logic [AW-1:0]              owner_b;

  logic [CW-1:0]              last_idx;
  logic [AW-1:0]              link_raddr;
  logic                       link_we;
  logic [AW-1:0]              link_waddr;
  logic [CW-1:0]              link_wdata;
  logic                       dense_we;
  logic [AW-1:0]              dense_waddr;
  logic [DATA_WIDTH-1:0]      dense_wval;
  logic [AW-1:0]              dense_wowner;
  logic                       gen_we;
  logic [AW-1:0]              gen_waddr;

  // result registers
  logic [1:0]                 res_status;
  logic [gsm_pkg::SLOT_W-1:0] res_slot;
  logic [gsm_pkg::KGEN_W-1:0] res_gen;
  logic [gsm_pkg::VALUE_W-1:0] res_value;

  assign last_idx = live_count - CW'(1);

  always_comb begin
    flags.is_insert    = (req_q == gsm_pkg::REQ_INSERT);
    flags.is_remove    = (req_q == gsm_pkg::REQ_REMOVE);
    flags.is_lookup    = (req_q == gsm_pkg::REQ_LOOKUP);
    flags.full         = (live_count == CW'(CAPACITY));
    flags.fresh        = (free_head >= high_water);
    flags.key_range_ok = (ks_q < XW'(high_water));
    flags.key1_ok      = (gen_rd == kg_q) && (link_rd < live_count);
    flags.owner_ok     = (XW'(owner_a) == ks_q);
    flags.moved        = (hole_q != last_idx);
  end

  // memory port steering
  always_comb begin
    link_raddr   = cmd.pop_rd ? free_head[AW-1:0] : ks_q[AW-1:0];
    link_we      = cmd.ins_write | cmd.rm_write | cmd.fix_write;
    link_waddr   = slot_q[AW-1:0];
    link_wdata   = live_count;
    if (cmd.rm_write) begin
      link_waddr = ks_q[AW-1:0];
      link_wdata = free_head;
    end else if (cmd.fix_write) begin
      link_waddr = owner_b;
      link_wdata = hole_q;
    end
    gen_we       = cmd.ins_write | cmd.rm_write;
    gen_waddr    = cmd.rm_write ? ks_q[AW-1:0] : slot_q[AW-1:0];
    dense_we     = cmd.ins_write | (cmd.rm_write & flags.moved);
    dense_waddr  = cmd.rm_write ? hole_q[AW-1:0] : live_count[AW-1:0];
    dense_wval   = cmd.rm_write ? val_b : val_q;
    dense_wowner = cmd.rm_write ? owner_b : slot_q[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      slot_link[link_waddr] <= link_wdata;
    end
    if (cmd.pop_rd || cmd.key_rd) begin
      link_rd <= slot_link[link_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (gen_we) begin
      slot_generation[gen_waddr] <= gen_counter;
    end
    if (cmd.key_rd) begin
      gen_rd <= slot_generation[ks_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (dense_we) begin
      dense_values[dense_waddr] <= dense_wval;
    end
    if (cmd.dense_rd) begin
      val_a <= dense_values[link_rd[AW-1:0]];
      val_b <= dense_values[last_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (dense_we) begin
      dense_owner[dense_waddr] <= dense_wowner;
    end
    if (cmd.dense_rd) begin
      owner_a <= dense_owner[link_rd[AW-1:0]];
      owner_b <= dense_owner[last_idx[AW-1:0]];
    end
  end

  // request capture and work registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_type;
      ks_q  <= XW'(key_slot);
      kg_q  <= GEN_WIDTH'(key_gen);
      val_q <= DATA_WIDTH'(value);
    end
    if (cmd.take_fresh) begin
      slot_q <= high_water;
    end else if (cmd.pop_rd) begin
      slot_q <= free_head;
    end
    if (cmd.dense_rd) begin
      hole_q <= link_rd;
    end
  end

  // table state
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head   <= '0;
      live_count  <= '0;
      high_water  <= '0;
      gen_counter <= '0;
    end else begin
      if (cmd.take_fresh) begin
        high_water <= high_water + CW'(1);
        free_head  <= high_water + CW'(1);
      end else if (cmd.pop_take) begin
        free_head <= link_rd;
      end else if (cmd.rm_write) begin
        free_head <= ks_q[CW-1:0];
      end
      if (cmd.ins_write) begin
        live_count  <= live_count + CW'(1);
        gen_counter <= gen_counter + GEN_WIDTH'(1);
      end else if (cmd.rm_write) begin
        live_count  <= last_idx;
        gen_counter <= gen_counter + GEN_WIDTH'(1);
      end
    end
  end

  // result build-up
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_status <= gsm_pkg::ST_OK;
      res_slot   <= '0;
      res_gen    <= '0;
      res_value  <= '0;
    end else begin
      if (cmd.set_full) begin
        res_status <= gsm_pkg::ST_FULL;
      end
      if (cmd.set_invalid) begin
        res_status <= gsm_pkg::ST_INVALID;
      end
      if (cmd.ins_write) begin
        res_slot <= gsm_pkg::SLOT_W'(slot_q);
        res_gen  <= gsm_pkg::KGEN_W'(gen_counter);
      end
      if (cmd.set_lookup) begin
        res_value <= gsm_pkg::VALUE_W'(val_a);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status    <= res_status;
      out_slot  <= res_slot;
      out_gen   <= res_gen;
      value_out <= res_value;
    end
  end

endmodule

FILE: hdl/gsm_ctrl.sv
module gsm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  gsm_pkg::flags_t flags,
  output gsm_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_INS_WR = 3'd3;
  localparam logic [2:0] S_KEY1   = 3'd4;
  localparam logic [2:0] S_KEY2   = 3'd5;
  localparam logic [2:0] S_FIX    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       m_tvalid_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (flags.is_insert) begin
          if (flags.full) begin
            cmd.set_full = 1'b1;
            state_next   = S_DONE;
          end else if (flags.fresh) begin
            cmd.take_fresh = 1'b1;
            state_next     = S_INS_WR;
          end else begin
            cmd.pop_rd = 1'b1;
            state_next = S_POP;
          end
        end else if ((flags.is_remove || flags.is_lookup) && flags.key_range_ok) begin
          cmd.key_rd = 1'b1;
          state_next = S_KEY1;
        end else begin
          cmd.set_invalid = 1'b1;
          state_next      = S_DONE;
        end
      end
      S_POP: begin
        cmd.pop_take = 1'b1;
        state_next   = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.ins_write = 1'b1;
        state_next    = S_DONE;
      end
      S_KEY1: begin
        if (flags.key1_ok) begin
          cmd.dense_rd = 1'b1;
          state_next   = S_KEY2;
        end else begin
          cmd.set_invalid = 1'b1;
          state_next      = S_DONE;
        end
      end
      S_KEY2: begin
        if (!flags.owner_ok) begin
          cmd.set_invalid = 1'b1;
          state_next      = S_DONE;
        end else if (flags.is_lookup) begin
          cmd.set_lookup = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd.rm_write = 1'b1;
          state_next   = flags.moved ? S_FIX : S_DONE;
        end
      end
      S_FIX: begin
        cmd.fix_write = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    m_tvalid_next = m_tvalid;
    priority if (cmd.out_load) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

FILE: hdl/generational_slot_map.sv
// Channel  Dir  Fields
// s        in   tuser: req_type | tdata: key_slot, key_gen, value
// m        out  tuser: status   | tdata: out_slot, out_gen, value_out
//
// One request at a time; input ready only in the idle state.
// Insert runs DECODE, POP (only when popping the free list), INS_WR, DONE;
// lookup DECODE, KEY1, KEY2, DONE; remove adds FIX after KEY2 when the last
// dense entry moves into the hole; a failed full or key check goes to DONE.
// A result waits in the output register while m stalls; the next request is
// taken once it is loaded. Reset clears counters only; tables need no clear.
`include "generational_slot_map_macros.svh"

module generational_slot_map #(
  parameter int CAPACITY   = gsm_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = gsm_pkg::DATA_WIDTH_DEF,
  parameter int GEN_WIDTH  = gsm_pkg::GEN_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [gsm_pkg::TDATA_W-1:0]   s_tdata,  // key_slot, key_gen, value
  input  logic [gsm_pkg::REQ_W-1:0]     s_tuser,  // req_type
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [gsm_pkg::TDATA_W-1:0]   m_tdata,  // out_slot, out_gen, value_out
  output logic [1:0]                    m_tuser   // status
);

  gsm_pkg::cmd_t   cmd;
  gsm_pkg::flags_t flags;

  logic [gsm_pkg::SLOT_W-1:0]  out_slot;
  logic [gsm_pkg::KGEN_W-1:0]  out_gen;
  logic [gsm_pkg::VALUE_W-1:0] value_out;

  gsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .flags    (flags),
    .cmd      (cmd)
  );

  gsm_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .GEN_WIDTH  (GEN_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .flags     (flags),
    .req_type  (s_tuser),
    .key_slot  (s_tdata[7:0]),
    .key_gen   (s_tdata[39:8]),
    .value     (s_tdata[71:40]),
    .status    (m_tuser),
    .out_slot  (out_slot),
    .out_gen   (out_gen),
    .value_out (value_out)
  );

  assign m_tdata = {value_out, out_gen, out_slot};

  `GSM_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second request taken while busy")
  `GSM_ASSERT_NOW(a_no_insert_when_full, cmd.ins_write, !flags.full, "insert written into full table")
  `GSM_ASSERT_NOW(a_fix_after_remove, cmd.fix_write, $past(cmd.rm_write), "back-map fix without remove")

endmodule

FILE: test/tb_generational_slot_map.sv
`timescale 1ns / 100ps

module tb_generational_slot_map;

  localparam int MAP_DEPTH = gsm_pkg::CAPACITY_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [gsm_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]                  status;
    logic [gsm_pkg::SLOT_W-1:0]  slot;
    logic [gsm_pkg::KGEN_W-1:0]  gen;
    logic [gsm_pkg::VALUE_W-1:0] word;
  } map_result_t;

  typedef enum int {
    NOISE_RANDOM_KEY,
    NOISE_STALE_KEY,
    NOISE_FREED_STAMP,
    NOISE_BAD_GEN,
    NOISE_UNKNOWN_REQ
  } noise_kind_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [gsm_pkg::TDATA_W-1:0]   s_tdata;   // key_slot, key_gen, value
  logic [gsm_pkg::REQ_W-1:0]     s_tuser;   // req_type
  logic                          m_tvalid;
  logic                          m_tready;
  logic [gsm_pkg::TDATA_W-1:0]   m_tdata;   // out_slot, out_gen, value_out
  logic [1:0]                    m_tuser;   // status

  // predicted table state
  logic [8:0]                  link_tab  [MAP_DEPTH];
  logic [gsm_pkg::KGEN_W-1:0]  gen_tab   [MAP_DEPTH];
  logic [gsm_pkg::VALUE_W-1:0] word_tab  [MAP_DEPTH];
  logic [gsm_pkg::SLOT_W-1:0]  owner_tab [MAP_DEPTH];
  logic [8:0]                  free_head;
  logic [8:0]                  live_cnt;
  logic [8:0]                  high_water;
  logic [gsm_pkg::KGEN_W-1:0]  gen_ctr;

  map_result_t        pending_results[$];
  logic [39:0]        stale_keys[$];   // {gen, slot}
  int                 errors = 0;
  int                 idle_cycles = 0;
  int                 stall_left = 0;
  bit                 calm = 1'b0;

  generational_slot_map i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [gsm_pkg::SLOT_W-1:0] random_slot(input int hi);
    logic [31:0] r;
    r = $urandom_range(0, hi);
    return r[gsm_pkg::SLOT_W-1:0];
  endfunction

  function automatic bit key_valid(input logic [gsm_pkg::SLOT_W-1:0] ks,
                                   input logic [gsm_pkg::KGEN_W-1:0] kg);
    logic [8:0] link;
    if ({1'b0, ks} >= high_water) return 1'b0;
    if (gen_tab[ks] != kg) return 1'b0;
    link = link_tab[ks];
    if (link >= live_cnt) return 1'b0;
    return owner_tab[link[7:0]] == ks;
  endfunction

  function automatic map_result_t apply_request(input logic [gsm_pkg::REQ_W-1:0] req,
                                                input logic [gsm_pkg::SLOT_W-1:0] ks,
                                                input logic [gsm_pkg::KGEN_W-1:0] kg,
                                                input logic [gsm_pkg::VALUE_W-1:0] val);
    map_result_t res;
    logic [8:0]  slot;
    logic [8:0]  hole;
    logic [8:0]  last;
    logic [gsm_pkg::SLOT_W-1:0] mover;
    res = '0;
    res.status = gsm_pkg::ST_OK;
    case (req)
      gsm_pkg::REQ_INSERT: begin
        if (live_cnt >= MAP_DEPTH) begin
          res.status = gsm_pkg::ST_FULL;
        end else begin
          if (free_head >= high_water) begin
            slot = high_water;
            high_water = high_water + 9'd1;
            free_head = high_water;
          end else begin
            slot = free_head;
            free_head = link_tab[slot[7:0]];
          end
          link_tab[slot[7:0]] = live_cnt;
          gen_tab[slot[7:0]] = gen_ctr;
          word_tab[live_cnt[7:0]] = val;
          owner_tab[live_cnt[7:0]] = slot[7:0];
          live_cnt = live_cnt + 9'd1;
          res.slot = slot[7:0];
          res.gen = gen_ctr;
          gen_ctr = gen_ctr + 1'b1;
        end
      end
      gsm_pkg::REQ_REMOVE: begin
        if (!key_valid(ks, kg)) begin
          res.status = gsm_pkg::ST_INVALID;
        end else begin
          hole = link_tab[ks];
          last = live_cnt - 9'd1;
          link_tab[ks] = free_head;
          gen_tab[ks] = gen_ctr;
          free_head = {1'b0, ks};
          if (hole != last) begin
            mover = owner_tab[last[7:0]];
            word_tab[hole[7:0]] = word_tab[last[7:0]];
            owner_tab[hole[7:0]] = mover;
            link_tab[mover] = hole;
          end
          live_cnt = last;
          gen_ctr = gen_ctr + 1'b1;
        end
      end
      gsm_pkg::REQ_LOOKUP: begin
        if (!key_valid(ks, kg)) res.status = gsm_pkg::ST_INVALID;
        else res.word = word_tab[link_tab[ks][7:0]];
      end
      default: res.status = gsm_pkg::ST_INVALID;
    endcase
    return res;
  endfunction

  task automatic send_req(input logic [gsm_pkg::REQ_W-1:0] req,
                          input logic [gsm_pkg::SLOT_W-1:0] ks,
                          input logic [gsm_pkg::KGEN_W-1:0] kg,
                          input logic [gsm_pkg::VALUE_W-1:0] val);
    map_result_t exp;
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {val, kg, ks};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    exp = apply_request(req, ks, kg, val);
    if (req == gsm_pkg::REQ_REMOVE && exp.status == gsm_pkg::ST_OK) begin
      stale_keys.push_back({kg, ks});
      if (stale_keys.size() > 64) void'(stale_keys.pop_front());
    end
    pending_results.push_back(exp);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic pick_live_key(output logic [gsm_pkg::SLOT_W-1:0] ks,
                               output logic [gsm_pkg::KGEN_W-1:0] kg);
    int idx;
    idx = $urandom_range(0, live_cnt - 1);
    ks = owner_tab[idx];
    kg = gen_tab[ks];
  endtask

  function automatic logic [gsm_pkg::VALUE_W-1:0] random_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic test_directed();
    send_req(gsm_pkg::REQ_LOOKUP, 8'd0, 32'd0, 32'd0);
    send_req(gsm_pkg::REQ_REMOVE, 8'd0, 32'd0, 32'd0);
    send_req(REQ_UNKNOWN, 8'hFF, '1, '1);
    send_req(REQ_UNKNOWN, 8'h00, '0, '0);
    send_req(gsm_pkg::REQ_INSERT, 8'hFF, '1, 32'h0000_0000);
    send_req(gsm_pkg::REQ_INSERT, 8'h00, '0, 32'hFFFF_FFFF);
    send_req(gsm_pkg::REQ_INSERT, 8'h5A, 32'h1234, 32'hA5A5_5A5A);
    send_req(gsm_pkg::REQ_LOOKUP, 8'd0, 32'd0, '1);
    send_req(gsm_pkg::REQ_LOOKUP, 8'd1, 32'd1, 32'd0);
    send_req(gsm_pkg::REQ_LOOKUP, 8'd1, 32'hFFFF_FFFF, 32'd0);
    send_req(gsm_pkg::REQ_LOOKUP, 8'hFF, 32'd0, 32'd0);
    // hole at the front, last entry moves in
    send_req(gsm_pkg::REQ_REMOVE, 8'd0, 32'd0, 32'd0);
    send_req(gsm_pkg::REQ_LOOKUP, 8'd2, 32'd2, 32'd0);
    // freed slot carries a fresh stamp but is not live
    send_req(gsm_pkg::REQ_LOOKUP, 8'd0, gen_tab[0], 32'd0);
    send_req(gsm_pkg::REQ_REMOVE, 8'd0, gen_tab[0], 32'd0);
    send_req(gsm_pkg::REQ_REMOVE, 8'd0, 32'd0, 32'd0);
    send_req(gsm_pkg::REQ_REMOVE, 8'd2, 32'd2, 32'd0);
    send_req(gsm_pkg::REQ_REMOVE, 8'd1, 32'd1, 32'd0);
    // three pops from the free list, then a fresh slot
    repeat (4) send_req(gsm_pkg::REQ_INSERT, random_slot(255), $urandom, $urandom);
    send_req(gsm_pkg::REQ_LOOKUP, 8'd3, gen_tab[3], 32'd0);
    wait_idle();
  endtask

  task automatic test_table_full();
    logic [gsm_pkg::SLOT_W-1:0] ks;
    logic [gsm_pkg::KGEN_W-1:0] kg;
    while (live_cnt < MAP_DEPTH) send_req(gsm_pkg::REQ_INSERT, random_slot(255), $urandom,
                                          random_word());
    repeat (2) send_req(gsm_pkg::REQ_INSERT, random_slot(255), $urandom, $urandom);
    send_req(gsm_pkg::REQ_LOOKUP, 8'hFF, gen_tab[255], 32'd0);
    pick_live_key(ks, kg);
    send_req(gsm_pkg::REQ_REMOVE, ks, kg, 32'd0);
    send_req(gsm_pkg::REQ_INSERT, random_slot(255), $urandom, $urandom);
    send_req(gsm_pkg::REQ_INSERT, random_slot(255), $urandom, $urandom);
    wait_idle();
  endtask

  task automatic test_random(input int count);
    int bias_ins;
    int r;
    noise_kind_t kind;
    logic [gsm_pkg::REQ_W-1:0]  req;
    logic [gsm_pkg::SLOT_W-1:0] ks;
    logic [gsm_pkg::KGEN_W-1:0] kg;
    logic [39:0]                old_key;
    bias_ins = 40;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        bias_ins = $urandom_range(15, 75);
        calm = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < bias_ins) begin
        send_req(gsm_pkg::REQ_INSERT, random_slot(255), $urandom, random_word());
      end else if (r < bias_ins + (100 - bias_ins) * 8 / 10 && live_cnt != 0) begin
        pick_live_key(ks, kg);
        req = ($urandom_range(0, 1) == 0) ? gsm_pkg::REQ_REMOVE : gsm_pkg::REQ_LOOKUP;
        send_req(req, ks, kg, $urandom);
      end else begin
        kind = noise_kind_t'($urandom_range(0, 4));
        req = ($urandom_range(0, 1) == 0) ? gsm_pkg::REQ_REMOVE : gsm_pkg::REQ_LOOKUP;
        ks = random_slot(255);
        kg = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 1023);
        case (kind)
          NOISE_STALE_KEY: begin
            if (stale_keys.size() != 0) begin
              old_key = stale_keys[$urandom_range(0, stale_keys.size() - 1)];
              ks = old_key[7:0];
              kg = old_key[39:8];
            end
          end
          NOISE_FREED_STAMP: begin
            if (high_water != 0) begin
              ks = random_slot(high_water - 1);
              kg = gen_tab[ks];
            end
          end
          NOISE_BAD_GEN: begin
            if (live_cnt != 0) begin
              pick_live_key(ks, kg);
              kg = kg ^ (32'd1 << $urandom_range(0, 31));
            end
          end
          NOISE_UNKNOWN_REQ: req = REQ_UNKNOWN;
          default: ;
        endcase
        send_req(req, ks, kg, $urandom);
      end
    end
    calm = 1'b0;
    wait_idle();
  endtask

  // result checker
  always @(posedge clk) begin
    map_result_t got;
    map_result_t exp;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tuser;
      got.slot = m_tdata[7:0];
      got.gen = m_tdata[39:8];
      got.word = m_tdata[71:40];
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d slot %0d gen %0d value %0h",
               got.status, got.slot, got.gen, got.word);
        errors++;
      end else begin
        exp = pending_results.pop_front();
        if (got.status !== exp.status) begin
          $error("status: expected %0d, actual %0d", exp.status, got.status);
          errors++;
        end
        if (got.slot !== exp.slot) begin
          $error("out_slot: expected %0d, actual %0d", exp.slot, got.slot);
          errors++;
        end
        if (got.gen !== exp.gen) begin
          $error("out_gen: expected %0d, actual %0d", exp.gen, got.gen);
          errors++;
        end
        if (got.word !== exp.word) begin
          $error("value_out: expected %0h, actual %0h", exp.word, got.word);
          errors++;
        end
      end
    end
  end

  // output stalls
  initial begin
    m_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (stall_left > 0 && !calm) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        stall_left = ($urandom_range(0, 99) < 25) ? pick_gap() + 1 : 0;
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    free_head = '0;
    live_cnt = '0;
    high_water = '0;
    gen_ctr = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(320);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
